FILE: src/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
// Used by the scan front end, the result queue and the top level.
// No dependencies.
`default_nettype none

package wbps_pkg;

  // Parameter defaults.
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed widths of the configuration registers and of the result fields.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int MASK_W      = 16;
  localparam int LENGTH_W    = 5;
  localparam int MATCH_OFF_W = 32;

  // Depth of the queue between the scan front end and the output.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 2'd3;

  // Current configuration as seen by the scan front end.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes_low;
    logic [CFG_DATA_W-1:0] pattern_bytes_high;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [LENGTH_W-1:0]   pattern_length;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                   found;
    logic [MATCH_OFF_W-1:0] match_offset;
  } result_t;

endpackage

`default_nettype wire

FILE: src/wbps_front.sv
// Scan front end: accepts stream bytes, keeps the byte window and counter,
// runs the masked pattern compare and pushes result items into the queue.
// Depends on wbps_pkg.
`default_nettype none

module wbps_front
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic    in_last,
  output logic         push_valid,
  input  wire logic    push_ready,
  output result_t      push_data
);

  localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  logic [7:0]             recent [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   reported;

  logic                   accept;
  logic [LEN_W-1:0]       eff_len;
  logic [OFFSET_BITS-1:0] len_m1;
  logic [7:0]             window [MAX_PATTERN];
  logic [127:0]           pattern;
  logic                   hit;
  logic                   emit;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign pattern  = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

  // Clamp the configured length into 1 .. MAX_PATTERN.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  assign len_m1 = OFFSET_BITS'(eff_len) - OFFSET_BITS'(1);

  // Window with the incoming byte in place 0 and older bytes above it.
  always_comb begin
    window[0] = in_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window[k] = recent[k-1];
    end
  end

  // Masked compare: pattern byte j meets window place len-1-j.
  always_comb begin
    int k;
    hit = (bytes_seen >= len_m1);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k = int'(eff_len) - 1 - j;
      if (j < int'(eff_len) && !cfg.wildcard_mask[j]) begin
        if (window[k[IDX_W-1:0]] != pattern[8*j +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // A result leaves when the scan is live and either matches or ends.
  assign emit       = !reported && (hit || in_last);
  assign push_valid = accept && emit;

  always_comb begin
    push_data.found        = hit;
    push_data.match_offset = hit ? MATCH_OFF_W'(bytes_seen - len_m1) : '0;
  end

  // Byte window shifts on every live byte.
  always_ff @(posedge clk) begin
    if (accept && !reported) begin
      recent[0] <= in_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  // Counter and match flag; the end of a stream restarts the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        bytes_seen <= '0;
        reported   <= 1'b0;
      end else if (!reported) begin
        if (bytes_seen != COUNT_MAX) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
        if (hit) begin
          reported <= 1'b1;
        end
      end
    end
  end

  // After a match, the rest of the stream produces no result.
  a_quiet_after_match: assert property (@(posedge clk) disable iff (rst)
    accept && reported |-> !push_valid)
    else $error("result pushed after a match was reported");

  // A stream end leaves a fresh scan behind.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> bytes_seen == '0 && !reported)
    else $error("scan not restarted after stream end");

  // A live byte below saturation advances the counter by one.
  a_count: assert property (@(posedge clk) disable iff (rst)
    accept && !in_last && !reported && bytes_seen != COUNT_MAX
      |=> bytes_seen == $past(bytes_seen) + OFFSET_BITS'(1))
    else $error("byte counter did not advance");

endmodule

`default_nettype wire

FILE: src/wbps_queue.sv
// Short result queue between the scan front end and the output channel.
// Lets either side stall on its own; the head drives the output directly.
// Depends on wbps_pkg.
`default_nettype none

module wbps_queue
  import wbps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire result_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output result_t      pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Fill count never passes the depth.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Pointer distance agrees with the fill count.
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(wr_ptr - rd_ptr) == PTR_W'(count))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: src/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scan: one byte per cycle while the result queue
// has room, set by the combinational masked window compare. A result enters
// the four-entry result queue in the cycle its byte is accepted and leaves
// from the queue head; the queue absorbs output stalls. Reset (rst,
// synchronous) restores the register defaults and empties the scan state
// and the queue. Depends on wbps_pkg.
`default_nettype none

module wildcard_byte_pattern_scan
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port.
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  wire logic                   s_axis_tlast,   // stream_end
  // Result stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [MATCH_OFF_W-1:0]      m_axis_tdata,   // [31:0] match_offset
  output logic                        m_axis_tuser    // found
);

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  result_t push_data;
  result_t pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes_low  <= '0;
      cfg.pattern_bytes_high <= '0;
      cfg.wildcard_mask      <= '0;
      cfg.pattern_length     <= LENGTH_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  cfg.pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH: cfg.pattern_bytes_high <= cfg_data;
        REG_WILDCARD:     cfg.wildcard_mask      <= cfg_data[MASK_W-1:0];
        REG_LENGTH:       cfg.pattern_length     <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: window, counter and compare.
  wbps_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Back end: result queue feeding the master side.
  wbps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (m_axis_tvalid),
    .pop_ready  (m_axis_tready),
    .pop_data   (pop_data)
  );

  assign m_axis_tdata = pop_data.match_offset;
  assign m_axis_tuser = pop_data.found;

endmodule

`default_nettype wire

FILE: tb/tb_wildcard_byte_pattern_scan.sv
// Self-checking testbench for wildcard_byte_pattern_scan: directed and random byte
// streams against an in-bench scan predictor, with random stalls on both stream sides.
// Depends on wbps_pkg and the wildcard_byte_pattern_scan RTL.
`default_nettype none

module tb_wildcard_byte_pattern_scan;
  import wbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET = 1550;
  localparam int WINDOW_DEPTH = 15;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;    // [7:0] data_byte
  logic                   s_axis_tlast = 1'b0;  // stream_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [MATCH_OFF_W-1:0] m_axis_tdata;         // [31:0] match_offset
  logic                   m_axis_tuser;         // found

  wildcard_byte_pattern_scan dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predicted registers and scan state.
  logic [CFG_DATA_W-1:0]  pat_lo = '0;
  logic [CFG_DATA_W-1:0]  pat_hi = '0;
  logic [MASK_W-1:0]      wild = '0;
  logic [LENGTH_W-1:0]    plen = 5'd1;
  logic [7:0]             window [WINDOW_DEPTH];
  logic [31:0]            seen_cnt = '0;
  bit                     reported = 1'b0;

  result_t                pending_results [$];
  result_t                oldest;
  int                     mismatches = 0;
  int                     items_sent = 0;
  int                     burst_left = 0;
  bit                     narrow_fill = 1'b0;
  int unsigned            rx_cycle = 0;
  int unsigned            rx_mode = 0;
  int unsigned            rx_hold = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int active_length();
    if (plen == 0) return 1;
    if (plen > 16) return 16;
    return int'(plen);
  endfunction

  function automatic logic [7:0] pattern_at(input int j);
    logic [2*CFG_DATA_W-1:0] both;
    both = {pat_hi, pat_lo};
    return both[8*j +: 8];
  endfunction

  function automatic void restart_scan();
    for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;
    seen_cnt = '0;
    reported = 1'b0;
  endfunction

  // Consumes one byte; returns 1 when the byte produces a result.
  function automatic bit scan_byte(input logic [7:0] b, input bit last, output result_t r);
    int   eff;
    int   j;
    bit   hit;
    bit   has;
    logic [7:0] have;
    has = 1'b0;
    r = '0;
    eff = active_length();
    if (!reported) begin
      hit = (seen_cnt >= 32'(eff - 1));
      for (j = 0; j < eff; j++) begin
        if (hit && !wild[j]) begin
          have = (j == eff - 1) ? b : window[eff - 2 - j];
          if (have != pattern_at(j)) hit = 1'b0;
        end
      end
      if (hit) begin
        r.found = 1'b1;
        r.match_offset = seen_cnt - 32'(eff - 1);
        reported = 1'b1;
        has = 1'b1;
      end else if (last) begin
        has = 1'b1;
      end
      for (j = WINDOW_DEPTH - 1; j > 0; j--) window[j] = window[j-1];
      window[0] = b;
      if (seen_cnt != '1) seen_cnt = seen_cnt + 1;
    end
    if (last) restart_scan();
    return has;
  endfunction

  // Stops the sender and waits until every expected result has arrived, then
  // lets the pipeline drain for bytes that cause no result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller lowers the enable after the last one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  pat_lo = v;
      REG_PATTERN_HIGH: pat_hi = v;
      REG_WILDCARD:     wild = v[MASK_W-1:0];
      REG_LENGTH:       plen = v[LENGTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [CFG_DATA_W-1:0] mask, input logic [CFG_DATA_W-1:0] len);
    settle();
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_WILDCARD, mask);
    write_reg(REG_LENGTH, len);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one byte in bursts separated by random gaps, then predicts its result.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          gap = 0;
          burst_left = $urandom_range(30, 80);
        end
        1: begin
          gap = $urandom_range(4, 10);
          burst_left = $urandom_range(1, 6);
        end
        default: begin
          gap = $urandom_range(0, 3);
          burst_left = $urandom_range(1, 16);
        end
      endcase
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (scan_byte(b, last, r)) pending_results = {pending_results, r};
  endtask

  // Register defaults: a one-byte pattern of zero without wildcards.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Oversized length acts as sixteen; the window is then reconfigured mid-stream
  // to a zero length, which acts as one, and matches on the next byte.
  task automatic test_long_window_mid_stream();
    int i;
    load_config('0, '1, 64'hFFFF, 64'd31);
    for (i = 0; i < WINDOW_DEPTH; i++) send_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
    load_config(64'hFF, '0, '0, 64'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // A stream shorter than the pattern ends without a match even if all wildcards.
  task automatic test_short_stream();
    load_config('1, '1, 64'hFFFF, 64'd4);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
  endtask

  // A match completed by the marked last byte reports found and restarts.
  task automatic test_match_on_last_byte();
    load_config(64'h00FF, '0, '0, 64'd2);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  function automatic logic [7:0] filler_byte();
    if (!narrow_fill) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pattern_at($urandom_range(0, 15));
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] lo, hi, mask, len;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    mask = {$urandom, $urandom};
    len  = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: lo = '0;
      1: lo = '1;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: hi = '0;
      1: hi = '1;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: mask[MASK_W-1:0] = '0;
      1: mask[MASK_W-1:0] = '1;
      2: mask[MASK_W-1:0] = 16'($urandom & $urandom);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: len[LENGTH_W-1:0] = 5'd1;
      1: len[LENGTH_W-1:0] = 5'd16;
      2: len[LENGTH_W-1:0] = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
      default: len[LENGTH_W-1:0] = 5'($urandom_range(2, 15));
    endcase
    load_config(lo, hi, mask, len);
  endtask

  // Mostly streams carrying the pattern with random wildcard content, some with
  // one broken byte, the rest plain filler.
  task automatic random_stream(input bit close_it);
    logic [7:0] bytes_q [$];
    int         total, kind, at, eff, j;
    eff  = active_length();
    kind = $urandom_range(0, 9);
    if (kind < 7) total = eff + $urandom_range(0, 20);
    else if ($urandom_range(0, 9) == 0) total = $urandom_range(40, 90);
    else total = $urandom_range(1, 24);
    for (j = 0; j < total; j++) bytes_q = {bytes_q, filler_byte()};
    if (kind < 7) begin
      at = $urandom_range(0, total - eff);
      for (j = 0; j < eff; j++)
        bytes_q[at+j] = wild[j] ? 8'($urandom_range(0, 255)) : pattern_at(j);
      if (kind >= 5) begin
        j = $urandom_range(0, eff - 1);
        if (!wild[j]) bytes_q[at+j] = bytes_q[at+j] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (j = 0; j < total; j++) send_byte(bytes_q[j], close_it && (j == total - 1));
  endtask

  // Phases of random settings; the last stream of a phase is sometimes left open
  // so that the next settings apply in the middle of it.
  task automatic test_random_scans();
    int streams, s;
    while (items_sent < ITEMS_TARGET) begin
      random_config();
      narrow_fill = $urandom_range(0, 1);
      streams = $urandom_range(2, 12);
      for (s = 0; s < streams; s++)
        random_stream((s < streams - 1) || ($urandom_range(0, 3) != 0));
    end
  endtask

  // Result receiver: stalls in a pattern that it picks anew at random.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 11);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= rx_cycle[0];
      endcase
    end
  end

  // Compares each result transaction with the oldest predicted one.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0d, match_offset %0d", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (m_axis_tuser !== oldest.found) begin
          $error("found: expected %0d, actual %0d", oldest.found, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata !== oldest.match_offset) begin
          $error("match_offset: expected %0d, actual %0d", oldest.match_offset, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    restart_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_long_window_mid_stream();
    test_short_stream();
    test_match_on_last_byte();
    test_random_scans();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
